// ----- rtl/core/dvr_pkg.sv -----
// Shared constants, codes and the CORDIC arctangent table of the direction vector rotator.
package dvr_pkg;

   // Operation codes carried by a request.
   localparam logic [2:0] FN_AXIS  = 3'd0;
   localparam logic [2:0] FN_ROLL  = 3'd1;
   localparam logic [2:0] FN_PITCH = 3'd2;
   localparam logic [2:0] FN_YAW   = 3'd3;
   localparam logic [2:0] FN_TRANS = 3'd4;
   localparam logic [2:0] FN_LOAD  = 3'd5;

   localparam int DEF_CORDIC_STEPS = 16;
   localparam int DEF_FRAC_BITS    = 14;
   localparam int CORDIC_FRAC      = 30;

   // Initial x of the rotation-mode CORDIC, reciprocal of the limit gain on 30 fraction bits.
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // Multiplier sequence: axis products, sine products, matrix terms, matrix-vector product.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] ST_XX  = 5'd0;
   localparam logic [STEP_W-1:0] ST_YY  = 5'd1;
   localparam logic [STEP_W-1:0] ST_ZZ  = 5'd2;
   localparam logic [STEP_W-1:0] ST_XY  = 5'd3;
   localparam logic [STEP_W-1:0] ST_XZ  = 5'd4;
   localparam logic [STEP_W-1:0] ST_YZ  = 5'd5;
   localparam logic [STEP_W-1:0] ST_SX  = 5'd6;
   localparam logic [STEP_W-1:0] ST_SY  = 5'd7;
   localparam logic [STEP_W-1:0] ST_SZ  = 5'd8;
   localparam logic [STEP_W-1:0] ST_M00 = 5'd9;
   localparam logic [STEP_W-1:0] ST_M11 = 5'd10;
   localparam logic [STEP_W-1:0] ST_M22 = 5'd11;
   localparam logic [STEP_W-1:0] ST_M01 = 5'd12;
   localparam logic [STEP_W-1:0] ST_M02 = 5'd13;
   localparam logic [STEP_W-1:0] ST_M10 = 5'd14;
   localparam logic [STEP_W-1:0] ST_M12 = 5'd15;
   localparam logic [STEP_W-1:0] ST_M20 = 5'd16;
   localparam logic [STEP_W-1:0] ST_M21 = 5'd17;
   localparam logic [STEP_W-1:0] ST_A0  = 5'd18;
   localparam logic [STEP_W-1:0] ST_A1  = 5'd19;
   localparam logic [STEP_W-1:0] ST_A2  = 5'd20;
   localparam logic [STEP_W-1:0] ST_A3  = 5'd21;
   localparam logic [STEP_W-1:0] ST_A4  = 5'd22;
   localparam logic [STEP_W-1:0] ST_A5  = 5'd23;
   localparam logic [STEP_W-1:0] ST_A6  = 5'd24;
   localparam logic [STEP_W-1:0] ST_A7  = 5'd25;
   localparam logic [STEP_W-1:0] ST_A8  = 5'd26;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;
      logic                cordic_step;
      logic [4:0]          iter;
      logic                finish;
      logic                mul;
      logic [STEP_W-1:0]   step;
      logic                update;
      logic                out_load;
   } cmd_type;

   // Arctangent of 2^-i as phase, a full turn at 2^32.
   function automatic logic [31:0] atan_phase(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/dvr_ctrl.sv -----
// Controller state machine that sequences the CORDIC, the multiplier and the result handoff.
module dvr_ctrl import dvr_pkg::*; #(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd
);

   localparam int IW = $clog2(CORDIC_STEPS);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CORDIC = 7'b0000010,
      S_FINISH = 7'b0000100,
      S_MUL    = 7'b0001000,
      S_DRAIN  = 7'b0010000,
      S_UPDATE = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [IW-1:0]     iter_ff, iter_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              axis_ff, axis_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.iter     = 5'(iter_ff);
      cmd.step     = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               axis_in     = (req_func == FN_AXIS);
               iter_in     = '0;
               if (req_func == FN_AXIS || req_func == FN_ROLL || req_func == FN_PITCH ||
                   req_func == FN_YAW) begin
                  state_in = S_CORDIC;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            iter_in         = iter_ff + 1'b1;
            if (iter_ff == IW'(CORDIC_STEPS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            step_in    = axis_ff ? ST_XX : ST_A0;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == ST_A8) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         step_ff      <= '0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_mul_ends_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && step_ff == ST_A8) |=> (state_ff == S_DRAIN))
      else $error("multiplier sequence did not end after the last product");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && rsp_valid_ff) |-> rsp_ready)
      else $error("result register overwritten before it was taken");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CORDIC || state_ff == S_UPDATE))
      else $error("accepted request did not start work");

   a_iter_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORDIC) |-> (iter_ff <= IW'(CORDIC_STEPS - 1)))
      else $error("CORDIC iteration count out of range");

endmodule

// ----- rtl/core/dvr_datapath.sv -----
// Datapath: CORDIC, shared multiplier, rotation matrix terms, direction and position state.
module dvr_datapath import dvr_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [2:0]         req_func,
   input  logic [15:0]        req_angle,
   input  logic signed [15:0] req_vec_x,
   input  logic signed [15:0] req_vec_y,
   input  logic signed [15:0] req_vec_z,
   input  logic signed [31:0] req_shift_x,
   input  logic signed [31:0] req_shift_y,
   input  logic signed [31:0] req_shift_z,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic signed [15:0] rsp_dir_z,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z
);

   localparam int SH_C = CORDIC_FRAC - FRAC_BITS;
   localparam logic signed [33:0] RND_C = 34'sd1 <<< (SH_C - 1);
   localparam logic signed [33:0] QTR   = 34'sd1073741824;
   localparam logic signed [33:0] HALFT = 34'sd2147483648;
   localparam logic signed [17:0] ONE18 = 18'sd1 <<< FRAC_BITS;
   localparam logic signed [33:0] ONE2  = 34'sd1 <<< (2 * FRAC_BITS);
   localparam logic signed [53:0] RND2  = 54'sd1 <<< (2 * FRAC_BITS - 1);
   localparam logic signed [51:0] RND1  = 52'sd1 <<< (FRAC_BITS - 1);

   // Captured request.
   logic [2:0]         func_ff;
   logic signed [15:0] vx_ff, vy_ff, vz_ff;
   logic signed [31:0] tx_ff, ty_ff, tz_ff;

   // CORDIC.
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               neg_ff;
   logic signed [17:0] c_ff, s_ff;

   // Multiplier and intermediate terms.
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] prod_ff;
   logic               fire_ff;
   logic [STEP_W-1:0]  step_d_ff;
   logic signed [33:0] pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   logic signed [33:0] sx_ff, sy_ff, sz_ff;
   logic signed [23:0] m_ff [9];
   logic signed [51:0] acc_ff;
   logic signed [15:0] nd_ff [3];

   // State.
   logic signed [15:0] dir_ff [3];
   logic signed [31:0] pos_ff [3];

   logic signed [33:0] z_init, z_fold, atan_v, x_fin, y_fin, c_r, s_r;
   logic               neg_init;
   logic signed [17:0] omc;

   always_comb begin
      z_init   = 34'(signed'({req_angle, 16'h0000}));
      z_fold   = z_init;
      neg_init = 1'b0;
      if (z_init > QTR) begin
         z_fold   = z_init - HALFT;
         neg_init = 1'b1;
      end else if (z_init < -QTR) begin
         z_fold   = z_init + HALFT;
         neg_init = 1'b1;
      end
      atan_v = 34'(signed'({2'b00, atan_phase(cmd.iter)}));
      x_fin  = neg_ff ? -x_ff : x_ff;
      y_fin  = neg_ff ? -y_ff : y_ff;
      c_r    = (x_fin + RND_C) >>> SH_C;
      s_r    = (y_fin + RND_C) >>> SH_C;
      omc    = ONE18 - c_ff;
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         ST_XX:  begin mul_a = 34'(vx_ff); mul_b = 18'(vx_ff); end
         ST_YY:  begin mul_a = 34'(vy_ff); mul_b = 18'(vy_ff); end
         ST_ZZ:  begin mul_a = 34'(vz_ff); mul_b = 18'(vz_ff); end
         ST_XY:  begin mul_a = 34'(vx_ff); mul_b = 18'(vy_ff); end
         ST_XZ:  begin mul_a = 34'(vx_ff); mul_b = 18'(vz_ff); end
         ST_YZ:  begin mul_a = 34'(vy_ff); mul_b = 18'(vz_ff); end
         ST_SX:  begin mul_a = 34'(vx_ff); mul_b = s_ff; end
         ST_SY:  begin mul_a = 34'(vy_ff); mul_b = s_ff; end
         ST_SZ:  begin mul_a = 34'(vz_ff); mul_b = s_ff; end
         ST_M00: begin mul_a = ONE2 - pxx_ff; mul_b = c_ff; end
         ST_M11: begin mul_a = ONE2 - pyy_ff; mul_b = c_ff; end
         ST_M22: begin mul_a = ONE2 - pzz_ff; mul_b = c_ff; end
         ST_M01: begin mul_a = pxy_ff; mul_b = omc; end
         ST_M02: begin mul_a = pxz_ff; mul_b = omc; end
         ST_M10: begin mul_a = pxy_ff; mul_b = omc; end
         ST_M12: begin mul_a = pyz_ff; mul_b = omc; end
         ST_M20: begin mul_a = pxz_ff; mul_b = omc; end
         ST_M21: begin mul_a = pyz_ff; mul_b = omc; end
         ST_A0:  begin mul_a = 34'(m_ff[0]); mul_b = 18'(dir_ff[0]); end
         ST_A1:  begin mul_a = 34'(m_ff[1]); mul_b = 18'(dir_ff[1]); end
         ST_A2:  begin mul_a = 34'(m_ff[2]); mul_b = 18'(dir_ff[2]); end
         ST_A3:  begin mul_a = 34'(m_ff[3]); mul_b = 18'(dir_ff[0]); end
         ST_A4:  begin mul_a = 34'(m_ff[4]); mul_b = 18'(dir_ff[1]); end
         ST_A5:  begin mul_a = 34'(m_ff[5]); mul_b = 18'(dir_ff[2]); end
         ST_A6:  begin mul_a = 34'(m_ff[6]); mul_b = 18'(dir_ff[0]); end
         ST_A7:  begin mul_a = 34'(m_ff[7]); mul_b = 18'(dir_ff[1]); end
         ST_A8:  begin mul_a = 34'(m_ff[8]); mul_b = 18'(dir_ff[2]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Matrix term and matrix-vector accumulation from the registered product.
   logic signed [53:0] prod54, vsum, vrnd;
   logic [3:0]         m_idx;
   logic               m_wr;
   logic signed [51:0] acc_sum, acc_rnd;
   logic               acc_first, acc_last;
   logic [1:0]         row;
   logic signed [15:0] acc_sat;

   always_comb begin
      prod54 = 54'(prod_ff);
      vsum   = prod54;
      m_idx  = 4'd0;
      m_wr   = 1'b0;
      case (step_d_ff)
         ST_M00: begin vsum = prod54 + (54'(pxx_ff) <<< FRAC_BITS); m_idx = 4'd0; m_wr = 1'b1; end
         ST_M11: begin vsum = prod54 + (54'(pyy_ff) <<< FRAC_BITS); m_idx = 4'd4; m_wr = 1'b1; end
         ST_M22: begin vsum = prod54 + (54'(pzz_ff) <<< FRAC_BITS); m_idx = 4'd8; m_wr = 1'b1; end
         ST_M01: begin vsum = prod54 - (54'(sz_ff) <<< FRAC_BITS); m_idx = 4'd1; m_wr = 1'b1; end
         ST_M02: begin vsum = prod54 + (54'(sy_ff) <<< FRAC_BITS); m_idx = 4'd2; m_wr = 1'b1; end
         ST_M10: begin vsum = prod54 + (54'(sz_ff) <<< FRAC_BITS); m_idx = 4'd3; m_wr = 1'b1; end
         ST_M12: begin vsum = prod54 - (54'(sx_ff) <<< FRAC_BITS); m_idx = 4'd5; m_wr = 1'b1; end
         ST_M20: begin vsum = prod54 - (54'(sy_ff) <<< FRAC_BITS); m_idx = 4'd6; m_wr = 1'b1; end
         ST_M21: begin vsum = prod54 + (54'(sx_ff) <<< FRAC_BITS); m_idx = 4'd7; m_wr = 1'b1; end
         default: begin vsum = prod54; m_idx = 4'd0; m_wr = 1'b0; end
      endcase
      vrnd = (vsum + RND2) >>> (2 * FRAC_BITS);

      acc_first = (step_d_ff == ST_A0) || (step_d_ff == ST_A3) || (step_d_ff == ST_A6);
      acc_last  = (step_d_ff == ST_A2) || (step_d_ff == ST_A5) || (step_d_ff == ST_A8);
      row       = (step_d_ff == ST_A2) ? 2'd0 : ((step_d_ff == ST_A5) ? 2'd1 : 2'd2);
      acc_sum   = (acc_first ? 52'sd0 : acc_ff) + prod_ff;
      acc_rnd   = (acc_sum + RND1) >>> FRAC_BITS;
      if (acc_rnd > 52'sd32767) begin
         acc_sat = 16'sh7FFF;
      end else if (acc_rnd < -52'sd32768) begin
         acc_sat = 16'sh8000;
      end else begin
         acc_sat = acc_rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         vx_ff   <= req_vec_x;
         vy_ff   <= req_vec_y;
         vz_ff   <= req_vec_z;
         tx_ff   <= req_shift_x;
         ty_ff   <= req_shift_y;
         tz_ff   <= req_shift_z;
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= z_fold;
         neg_ff  <= neg_init;
      end else if (cmd.cordic_step) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - (y_ff >>> cmd.iter);
            y_ff <= y_ff + (x_ff >>> cmd.iter);
            z_ff <= z_ff - atan_v;
         end else begin
            x_ff <= x_ff + (y_ff >>> cmd.iter);
            y_ff <= y_ff - (x_ff >>> cmd.iter);
            z_ff <= z_ff + atan_v;
         end
      end
      if (cmd.finish) begin
         c_ff <= c_r[17:0];
         s_ff <= s_r[17:0];
         // Axis-aligned rotations load their matrix straight from sine and cosine.
         for (int i = 0; i < 9; i++) begin
            m_ff[i] <= (i == 0 || i == 4 || i == 8) ? 24'(ONE18) : 24'sd0;
         end
         case (func_ff)
            FN_ROLL: begin
               m_ff[4] <= 24'(c_r); m_ff[5] <= -24'(s_r);
               m_ff[7] <= 24'(s_r); m_ff[8] <= 24'(c_r);
            end
            FN_PITCH: begin
               m_ff[0] <= 24'(c_r); m_ff[2] <= 24'(s_r);
               m_ff[6] <= -24'(s_r); m_ff[8] <= 24'(c_r);
            end
            FN_YAW: begin
               m_ff[0] <= 24'(c_r); m_ff[1] <= -24'(s_r);
               m_ff[3] <= 24'(s_r); m_ff[4] <= 24'(c_r);
            end
            default: begin
            end
         endcase
      end
      prod_ff   <= mul_a * mul_b;
      step_d_ff <= cmd.step;
      if (fire_ff) begin
         case (step_d_ff)
            ST_XX: pxx_ff <= prod_ff[33:0];
            ST_YY: pyy_ff <= prod_ff[33:0];
            ST_ZZ: pzz_ff <= prod_ff[33:0];
            ST_XY: pxy_ff <= prod_ff[33:0];
            ST_XZ: pxz_ff <= prod_ff[33:0];
            ST_YZ: pyz_ff <= prod_ff[33:0];
            ST_SX: sx_ff  <= prod_ff[33:0];
            ST_SY: sy_ff  <= prod_ff[33:0];
            ST_SZ: sz_ff  <= prod_ff[33:0];
            default: begin
            end
         endcase
         if (m_wr) begin
            m_ff[m_idx] <= vrnd[23:0];
         end
         acc_ff <= acc_sum;
         if (acc_last) begin
            nd_ff[row] <= acc_sat;
         end
      end
      if (cmd.out_load) begin
         rsp_dir_x <= dir_ff[0];
         rsp_dir_y <= dir_ff[1];
         rsp_dir_z <= dir_ff[2];
         rsp_pos_x <= pos_ff[0];
         rsp_pos_y <= pos_ff[1];
         rsp_pos_z <= pos_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fire_ff   <= 1'b0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= 16'(ONE18);
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
      end else begin
         fire_ff <= cmd.mul;
         if (cmd.update) begin
            case (func_ff)
               FN_AXIS, FN_ROLL, FN_PITCH, FN_YAW: begin
                  dir_ff[0] <= nd_ff[0];
                  dir_ff[1] <= nd_ff[1];
                  dir_ff[2] <= nd_ff[2];
               end
               FN_TRANS: begin
                  pos_ff[0] <= pos_ff[0] + tx_ff;
                  pos_ff[1] <= pos_ff[1] + ty_ff;
                  pos_ff[2] <= pos_ff[2] + tz_ff;
               end
               FN_LOAD: begin
                  dir_ff[0] <= vx_ff;
                  dir_ff[1] <= vy_ff;
                  dir_ff[2] <= vz_ff;
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// ----- rtl/core/direction_vector_rotator_top.sv -----
// Top level of the direction vector rotator: controller plus datapath behind valid/ready ports.
// The block keeps a direction (Q2.14, saturating) and a position (Q16.16, wrapping) and
// applies one operation per request: axis-angle rotation, roll, pitch or yaw, translation,
// or loading a new direction. Every request returns one result with the whole updated
// state. One request is worked on at a time. A rotation about an arbitrary axis runs
// CORDIC_STEPS iterations of the sine/cosine unit, a finishing step, then 27 passes
// through the single shared 34x18 multiplier for the axis products, the sine products,
// the nine matrix terms and the matrix-vector product, then a drain step, an update
// step and the load of the output register; roll, pitch and yaw skip the axis-product,
// sine-product and matrix-term passes; translate, load and the unused codes go straight
// to the update step and the output load. A new request is accepted as soon as the
// previous result has been placed in the output register, even if that result has not
// yet been taken; the next result is loaded only once the previous one has been taken.
module direction_vector_rotator_top import dvr_pkg::*; #(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic [15:0]        req_angle,
   input  logic signed [15:0] req_vec_x,
   input  logic signed [15:0] req_vec_y,
   input  logic signed [15:0] req_vec_z,
   input  logic signed [31:0] req_shift_x,
   input  logic signed [31:0] req_shift_y,
   input  logic signed [31:0] req_shift_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic signed [15:0] rsp_dir_z,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z
);

   // Commands from the state machine into the datapath.
   cmd_type cmd;

   dvr_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath captures the request, runs the arithmetic and holds the result register.
   dvr_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_func    (req_func),
      .req_angle   (req_angle),
      .req_vec_x   (req_vec_x),
      .req_vec_y   (req_vec_y),
      .req_vec_z   (req_vec_z),
      .req_shift_x (req_shift_x),
      .req_shift_y (req_shift_y),
      .req_shift_z (req_shift_z),
      .rsp_dir_x   (rsp_dir_x),
      .rsp_dir_y   (rsp_dir_y),
      .rsp_dir_z   (rsp_dir_z),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_pos_z   (rsp_pos_z)
   );

endmodule
